// ===== design/shs_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
// Used by shs_compress and sha256_stream_hasher_top; depends on nothing else.
`default_nettype none

package shs_pkg;

	localparam int WORD_W    = 32;
	localparam int BLOCK_W   = 512;
	localparam int FILL_W    = 6;
	localparam int ROUND_W   = 6;
	localparam int LEN_W     = 64;

	typedef logic [WORD_W-1:0]          word_t;
	typedef logic [7:0][WORD_W-1:0]     chain_t;
	typedef logic [15:0][WORD_W-1:0]    window_t;
	typedef logic [BLOCK_W-1:0]         block_t;

	localparam chain_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
	localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
	localparam logic [FILL_W-1:0] FILL_LEN  = 6'd56;
	localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;

	typedef struct packed {
		logic start;
		logic init;
	} shs_ctrl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} shs_stat_t;

	typedef enum logic [1:0] {
		CORE_IDLE,
		CORE_ROUND,
		CORE_FOLD
	} core_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_MARK,
		ST_ZERO,
		ST_LEN,
		ST_FINISH
	} top_state_t;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t choose(input word_t e, input word_t f, input word_t g);
		choose = (e & f) ^ (~e & g);
	endfunction

	function automatic word_t majority(input word_t a, input word_t b, input word_t c);
		majority = (a & b) ^ (a & c) ^ (b & c);
	endfunction

	function automatic word_t round_k(input logic [ROUND_W-1:0] idx);
		case (idx)
			6'd0:  round_k = 32'h428a2f98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;
			6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;
			6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;
			6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;
			6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			6'd63: round_k = 32'hc67178f2;
			default: round_k = '0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== design/sha256_stream_hasher_top.sv =====
// SHA-256 stream hasher: one byte per beat; the 64th byte of a block holds the input
// while shs_compress starts, runs its 64 rounds and folds the chain. Closing a message
// feeds padding one byte per cycle outside the compressions, with one or two more
// compressions, then loads the digest.
// The digest waits in an output register. Reset loads the initial hash values,
// clears the byte count and leaves the block idle and ready.
`default_nettype none

module sha256_stream_hasher_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  data_byte,
	input  wire         has_byte,
	input  wire         end_of_message,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [63:0] digest_high,
	output logic [63:0] digest_upper_mid,
	output logic [63:0] digest_lower_mid,
	output logic [63:0] digest_low
);

	shs_pkg::top_state_t            st_q, st_d;
	shs_pkg::top_state_t            ret_q, ret_d;
	logic [shs_pkg::FILL_W-1:0]     fill_q;
	logic [shs_pkg::LEN_W-1:0]      count_q;
	shs_pkg::block_t                buf_q;
	logic                           out_valid_q;
	logic [63:0]                    dig0_q, dig1_q, dig2_q, dig3_q;

	shs_pkg::shs_ctrl_t             ctrl;
	shs_pkg::shs_stat_t             stat;
	shs_pkg::chain_t                chain;

	logic                           shift_en;
	logic [7:0]                     shift_byte;
	logic                           count_en;
	logic                           load_out;
	logic [shs_pkg::LEN_W-1:0]      bit_len;
	logic [shs_pkg::LEN_W-1:0]      len_shifted;

	assign bit_len     = {count_q[shs_pkg::LEN_W-4:0], 3'b000};
	// fill 56..63 picks length bytes most significant first
	assign len_shifted = bit_len >> {~fill_q[2:0], 3'b000};

	always_comb begin
		st_d       = st_q;
		ret_d      = ret_q;
		shift_en   = 1'b0;
		shift_byte = '0;
		count_en   = 1'b0;
		load_out   = 1'b0;
		ctrl.start = 1'b0;
		ctrl.init  = 1'b0;
		case (st_q)
			shs_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (has_byte) begin
						shift_en   = 1'b1;
						shift_byte = data_byte;
						count_en   = 1'b1;
					end
					if (has_byte && fill_q == shs_pkg::FILL_LAST) begin
						st_d  = shs_pkg::ST_START;
						ret_d = end_of_message ? shs_pkg::ST_MARK : shs_pkg::ST_IDLE;
					end else if (end_of_message) begin
						st_d = shs_pkg::ST_MARK;
					end
				end
			end
			shs_pkg::ST_START: begin
				if (stat.idle) begin
					ctrl.start = 1'b1;
					st_d       = shs_pkg::ST_WAIT;
				end
			end
			shs_pkg::ST_WAIT: begin
				if (stat.done) begin
					st_d = ret_q;
				end
			end
			shs_pkg::ST_MARK: begin
				shift_en   = 1'b1;
				shift_byte = shs_pkg::PAD_MARK_BYTE;
				if (fill_q == shs_pkg::FILL_LAST) begin
					st_d  = shs_pkg::ST_START;
					ret_d = shs_pkg::ST_ZERO;
				end else begin
					st_d = shs_pkg::ST_ZERO;
				end
			end
			shs_pkg::ST_ZERO: begin
				if (fill_q == shs_pkg::FILL_LEN) begin
					st_d = shs_pkg::ST_LEN;
				end else begin
					shift_en = 1'b1;
					if (fill_q == shs_pkg::FILL_LAST) begin
						st_d  = shs_pkg::ST_START;
						ret_d = shs_pkg::ST_ZERO;
					end
				end
			end
			shs_pkg::ST_LEN: begin
				shift_en   = 1'b1;
				shift_byte = len_shifted[7:0];
				if (fill_q == shs_pkg::FILL_LAST) begin
					st_d  = shs_pkg::ST_START;
					ret_d = shs_pkg::ST_FINISH;
				end
			end
			shs_pkg::ST_FINISH: begin
				// hold until the previous digest has left
				if (!out_valid_q || out_ready) begin
					load_out  = 1'b1;
					ctrl.init = 1'b1;
					st_d      = shs_pkg::ST_IDLE;
				end
			end
			default: st_d = shs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= shs_pkg::ST_IDLE;
			ret_q       <= shs_pkg::ST_IDLE;
			fill_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			ret_q <= ret_d;
			if (shift_en) begin
				fill_q <= fill_q + 1'b1;
			end
			if (load_out) begin
				count_q <= '0;
			end else if (count_en) begin
				count_q <= count_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			buf_q <= {buf_q[shs_pkg::BLOCK_W-9:0], shift_byte};
		end
		if (load_out) begin
			dig0_q <= {chain[0], chain[1]};
			dig1_q <= {chain[2], chain[3]};
			dig2_q <= {chain[4], chain[5]};
			dig3_q <= {chain[6], chain[7]};
		end
	end

	shs_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.block  (buf_q),
		.stat   (stat),
		.chain  (chain)
	);

	assign in_ready         = (st_q == shs_pkg::ST_IDLE);
	assign out_valid        = out_valid_q;
	assign digest_high      = dig0_q;
	assign digest_upper_mid = dig1_q;
	assign digest_lower_mid = dig2_q;
	assign digest_low       = dig3_q;

endmodule

`default_nettype wire

// ===== design/shs_compress.sv =====
// SHA-256 compression engine: one round per cycle over a rolling 16-word schedule.
// Holds the chain value; depends on shs_pkg.
`default_nettype none

module shs_compress (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire shs_pkg::shs_ctrl_t ctrl,
	input  wire shs_pkg::block_t    block,
	output shs_pkg::shs_stat_t  stat,
	output shs_pkg::chain_t     chain
);

	shs_pkg::core_state_t              state_q, state_d;
	logic [shs_pkg::ROUND_W-1:0]       round_q;
	shs_pkg::window_t                  win_q;
	shs_pkg::chain_t                   wv_q;
	shs_pkg::chain_t                   chain_q;

	shs_pkg::word_t t1, t2, w_next;

	always_comb begin
		t1 = wv_q[7] + shs_pkg::big_sigma1(wv_q[4]) +
			shs_pkg::choose(wv_q[4], wv_q[5], wv_q[6]) +
			shs_pkg::round_k(round_q) + win_q[0];
		t2 = shs_pkg::big_sigma0(wv_q[0]) + shs_pkg::majority(wv_q[0], wv_q[1], wv_q[2]);
		// word sixteen rounds ahead of the one in use
		w_next = shs_pkg::small_sigma1(win_q[14]) + win_q[9] +
			shs_pkg::small_sigma0(win_q[1]) + win_q[0];
	end

	always_comb begin
		state_d   = state_q;
		stat.idle = 1'b0;
		stat.done = 1'b0;
		case (state_q)
			shs_pkg::CORE_IDLE: begin
				stat.idle = 1'b1;
				if (ctrl.start) begin
					state_d = shs_pkg::CORE_ROUND;
				end
			end
			shs_pkg::CORE_ROUND: begin
				if (round_q == shs_pkg::ROUND_LAST) begin
					state_d = shs_pkg::CORE_FOLD;
				end
			end
			shs_pkg::CORE_FOLD: begin
				stat.done = 1'b1;
				state_d   = shs_pkg::CORE_IDLE;
			end
			default: state_d = shs_pkg::CORE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shs_pkg::CORE_IDLE;
			round_q <= '0;
			chain_q <= shs_pkg::INIT_HASH;
		end else begin
			state_q <= state_d;
			case (state_q)
				shs_pkg::CORE_IDLE: begin
					round_q <= '0;
					if (ctrl.init) begin
						chain_q <= shs_pkg::INIT_HASH;
					end
				end
				shs_pkg::CORE_ROUND: begin
					round_q <= round_q + 1'b1;
				end
				shs_pkg::CORE_FOLD: begin
					for (int j = 0; j < 8; j++) begin
						chain_q[j] <= chain_q[j] + wv_q[j];
					end
				end
				default: round_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == shs_pkg::CORE_IDLE && ctrl.start) begin
			// first byte of the block sits in the top bits
			for (int j = 0; j < 16; j++) begin
				win_q[j] <= block[(15-j)*32 +: 32];
			end
			wv_q <= chain_q;
		end else if (state_q == shs_pkg::CORE_ROUND) begin
			win_q <= {w_next, win_q[15:1]};
			wv_q  <= {wv_q[6], wv_q[5], wv_q[4], wv_q[3] + t1,
				wv_q[2], wv_q[1], wv_q[0], t1 + t2};
		end
	end

	assign chain = chain_q;

endmodule

`default_nettype wire

// ===== verif/tb_sha256_stream_hasher_top.sv =====
// Self-checking bench for sha256_stream_hasher_top: byte beats in, 256-bit digests out.
// Carries its own SHA-256 digest predictor; depends only on the design files.

module tb_sha256_stream_hasher_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1600;
	localparam int CALM_TAIL   = 200;
	localparam int RX_HOLD_CYC = 600;
	localparam int IDLE_LIMIT  = 5000;
	localparam int TAIL_CYC    = 200;
	localparam int REPORT_MAX  = 10;

	localparam bit [31:0] K_TAB [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam bit [31:0] IV_TAB [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       eom;
		logic       drain_first;
		logic       hold_rx;
	} beat_t;

	typedef struct packed {
		logic [63:0] high;
		logic [63:0] upper_mid;
		logic [63:0] lower_mid;
		logic [63:0] low;
	} digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	beat_t       cur = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] digest_high;
	logic [63:0] digest_upper_mid;
	logic [63:0] digest_lower_mid;
	logic [63:0] digest_low;

	logic        in_beat = 1'b0;
	logic        calm = 1'b0;
	logic        rx_hold_req = 1'b0;
	int          tx_gap = 0;
	int          rx_gap = 0;
	int          rx_hold = 0;
	int          idle_cycles = 0;
	int          mismatch_cnt = 0;
	int          n_counted = 0;

	beat_t       tx_q [$];
	digest_t     digest_q [$];

	bit [31:0]   hash_st [8];
	bit [7:0]    blk_buf [64];
	bit [63:0]   msg_len;

	sha256_stream_hasher_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (cur.data),
		.has_byte         (cur.has_byte),
		.end_of_message   (cur.eom),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.digest_high      (digest_high),
		.digest_upper_mid (digest_upper_mid),
		.digest_lower_mid (digest_lower_mid),
		.digest_low       (digest_low)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit [31:0] ror32(bit [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void compress_block();
		bit [31:0] w [16];
		bit [31:0] v [8];
		bit [31:0] t1, t2, s0, s1, x2, x15;
		int j;
		int r;
		for (j = 0; j < 16; j++)
			w[j] = {blk_buf[4*j], blk_buf[4*j+1], blk_buf[4*j+2], blk_buf[4*j+3]};
		for (j = 0; j < 8; j++)
			v[j] = hash_st[j];
		for (r = 0; r < 64; r++) begin
			// extend the schedule in place over a 16-word window
			if (r >= 16) begin
				x2  = w[(r - 2) & 15];
				x15 = w[(r - 15) & 15];
				s1 = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
				s0 = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
				w[r & 15] = s1 + w[(r - 7) & 15] + s0 + w[r & 15];
			end
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + w[r & 15];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (j = 0; j < 8; j++)
			hash_st[j] = hash_st[j] + v[j];
	endfunction

	function automatic void restart_hash();
		int j;
		for (j = 0; j < 8; j++)
			hash_st[j] = IV_TAB[j];
		msg_len = '0;
	endfunction

	// Fold one accepted beat into the running hash; queue a digest on end of message.
	function automatic void absorb_beat(beat_t b);
		int fill;
		int j;
		bit [63:0] nbits;
		if (b.has_byte) begin
			blk_buf[msg_len[5:0]] = b.data;
			msg_len++;
			if (msg_len[5:0] == 6'd0)
				compress_block();
		end
		if (b.eom) begin
			fill = int'(msg_len[5:0]);
			blk_buf[fill] = 8'h80;
			fill++;
			// no room for the length field: close this block and pad a fresh one
			if (fill > 56) begin
				while (fill < 64) begin
					blk_buf[fill] = 8'h00;
					fill++;
				end
				compress_block();
				fill = 0;
			end
			while (fill < 56) begin
				blk_buf[fill] = 8'h00;
				fill++;
			end
			nbits = msg_len << 3;
			for (j = 0; j < 8; j++)
				blk_buf[56 + j] = nbits[63 - 8*j -: 8];
			compress_block();
			digest_q.push_back(digest_t'({hash_st[0], hash_st[1], hash_st[2], hash_st[3],
				hash_st[4], hash_st[5], hash_st[6], hash_st[7]}));
			restart_hash();
		end
	endfunction

	function automatic void push_beat(logic [7:0] d, logic hb, logic e, logic dr, logic hr);
		beat_t b;
		b.data        = d;
		b.has_byte    = hb;
		b.eom         = e;
		b.drain_first = dr;
		b.hold_rx     = hr;
		tx_q.push_back(b);
		if (hb || e)
			n_counted++;
	endfunction

	// One message of random bytes, with stray empty beats mixed in.
	function automatic void push_message(int len, bit drain, bit hold);
		bit sep_end;
		bit lead;
		int i;
		sep_end = (len == 0) ? 1'b1 : 1'($urandom_range(0, 1));
		lead = 1'b1;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, drain && lead, hold && lead);
				lead = 1'b0;
			end
			push_beat(8'($urandom_range(0, 255)), 1'b1, !sep_end && (i == len - 1),
				drain && lead, hold && lead);
			lead = 1'b0;
		end
		if (sep_end)
			push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain && lead, hold && lead);
	endfunction

	function automatic int pick_len();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 5) begin
			case ($urandom_range(0, 7))
				0: return 55;
				1: return 56;
				2: return 57;
				3: return 63;
				4: return 64;
				5: return 65;
				6: return 119;
				default: return 120;
			endcase
		end
		if (sel == 19)
			return $urandom_range(120, 200);
		return $urandom_range(0, 24);
	endfunction

	initial begin
		int msg_no;
		bit hold_done;
		restart_hash();

		push_beat(8'hff, 1'b0, 1'b1, 1'b0, 1'b0);	// empty message, data ignored
		push_beat(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);	// empty message again
		push_beat(8'h5a, 1'b0, 1'b0, 1'b0, 1'b0);	// empty beat, no effect
		push_beat(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
		push_beat(8'h62, 1'b1, 1'b0, 1'b0, 1'b0);
		push_beat(8'h63, 1'b1, 1'b1, 1'b0, 1'b0);	// last byte closes the message
		push_beat(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
		push_beat(8'hff, 1'b0, 1'b0, 1'b0, 1'b0);
		push_beat(8'hff, 1'b1, 1'b0, 1'b0, 1'b0);
		push_beat(8'ha5, 1'b0, 1'b1, 1'b0, 1'b0);	// close on a beat of its own
		push_beat(8'h80, 1'b1, 1'b1, 1'b0, 1'b0);
		push_beat(8'h7f, 1'b1, 1'b1, 1'b0, 1'b0);

		// padding boundaries: length field fits, just misses, full block
		push_message(55, 1'b1, 1'b0);
		push_message(56, 1'b0, 1'b0);
		push_message(64, 1'b0, 1'b0);

		hold_done = 1'b0;
		msg_no = 0;
		while (n_counted < ITEM_TARGET) begin
			msg_no++;
			if (!hold_done && n_counted > ITEM_TARGET / 3) begin
				// short messages against a stalled receiver, then drain
				push_message($urandom_range(0, 3), 1'b0, 1'b1);
				repeat (7) push_message($urandom_range(0, 3), 1'b0, 1'b0);
				push_message(pick_len(), 1'b1, 1'b0);
				hold_done = 1'b1;
			end else begin
				push_message(pick_len(), (msg_no % 12) == 0, 1'b0);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (tx_q.size() != 0 || in_valid || digest_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);

		if (mismatch_cnt == 0 && digest_q.size() == 0)
			$display("tb_sha256_stream_hasher_top OK");
		else
			$display("tb_sha256_stream_hasher_top NOT OK");
		$finish;
	end

	// Sender: advance only after a beat is taken, hold payload otherwise.
	always @(negedge clk) begin
		logic  nxt_valid;
		logic  nxt_hold;
		beat_t nxt;
		nxt_valid = in_valid;
		nxt_hold  = 1'b0;
		nxt       = cur;
		if (arst_n && (!in_valid || in_beat)) begin
			nxt_valid = 1'b0;
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (tx_q.size() != 0 && !(tx_q[0].drain_first && digest_q.size() != 0)) begin
				if (!calm && $urandom_range(0, 9) == 0) begin
					tx_gap = $urandom_range(1, 13) - 1;
				end else begin
					nxt       = tx_q.pop_front();
					nxt_valid = 1'b1;
					nxt_hold  = nxt.hold_rx;
				end
			end
		end
		in_valid    <= nxt_valid;
		cur         <= nxt;
		rx_hold_req <= nxt_hold;
	end

	// Receiver: random stall bursts plus one long hold-off on request.
	always @(negedge clk) begin
		logic nxt_rdy;
		nxt_rdy = 1'b1;
		if (rx_hold_req)
			rx_hold = RX_HOLD_CYC;
		if (rx_hold > 0) begin
			rx_hold--;
			nxt_rdy = 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			nxt_rdy = 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			rx_gap  = $urandom_range(1, 13) - 1;
			nxt_rdy = 1'b0;
		end
		out_ready <= nxt_rdy;
	end

	// Monitor: check digest beats, predict on input beats, watch for a hang.
	always @(posedge clk) begin
		digest_t want;
		logic    moved;
		logic [3:0] bad;
		if (arst_n) begin
			moved = 1'b0;
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (digest_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_MAX)
						$display("%0t: digest with none expected: %h %h %h %h", $realtime,
							digest_high, digest_upper_mid, digest_lower_mid, digest_low);
				end else begin
					want = digest_q.pop_front();
					bad[3] = digest_high !== want.high;
					bad[2] = digest_upper_mid !== want.upper_mid;
					bad[1] = digest_lower_mid !== want.lower_mid;
					bad[0] = digest_low !== want.low;
					if (bad != 4'b0000) begin
						mismatch_cnt++;
						if (mismatch_cnt <= REPORT_MAX) begin
							$display("%0t: digest mismatch, fields high..low %b", $realtime, bad);
							$display("  exp %h %h %h %h", want.high, want.upper_mid,
								want.lower_mid, want.low);
							$display("  got %h %h %h %h", digest_high, digest_upper_mid,
								digest_lower_mid, digest_low);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				moved = 1'b1;
				absorb_beat(cur);
			end
			in_beat <= in_valid && in_ready;
			calm    <= tx_q.size() < CALM_TAIL;
			if (moved) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("tb_sha256_stream_hasher_top NOT OK");
					$finish;
				end
			end
		end
	end

endmodule
